[sv/mcc_pkg.sv]
// Shared constants, types and calibration tables for the magnet field/current converter.
package mcc_pkg;

	// fixed point layout
	localparam int FRAC_BITS   = 16;
	localparam int IQ          = 28;
	localparam int CUR_TO_Q_SH = IQ - FRAC_BITS;
	localparam int STEP_SH     = 10 + FRAC_BITS;

	// datapath widths
	localparam int XW   = 25;
	localparam int UW   = 30;
	localparam int HW   = UW / 2;
	localparam int AW   = 40;
	localparam int FQW  = 36;
	localparam int DVW  = 68;
	localparam int QW   = 30;
	localparam int CNTW = 5;
	localparam int ITW  = 10;
	localparam int SW   = STEP_SH + 1;

	// limits
	localparam logic [XW-1:0] CUR_MAX   = XW'(500 * (1 << FRAC_BITS));
	localparam int            FIELD_LIM = 64 << FRAC_BITS;

	// u = x * 4096 / 300 = floor(x * U_RECIP / 2^32), exact for x below 2^25;
	// U_RECIP is ceil(2^42 / 75), the multiplier drops 28 bits, U_RECIP_SH the rest
	localparam logic [AW-1:0] U_RECIP    = AW'(64'd58640620149);
	localparam int            U_RECIP_SH = 4;

	// register reset values
	localparam logic [ITW-1:0] MAX_ITER_RST = ITW'(1000);
	localparam logic [15:0]    TOL_RST      = 16'd1;
	localparam logic [XW-1:0]  START_RST    = XW'(1 << FRAC_BITS);

	// codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOCONV  = 2'd1;
	localparam logic [1:0] ST_BADMAG  = 2'd2;
	localparam logic       OP_F2C     = 1'b0;
	localparam logic       OP_C2F     = 1'b1;
	localparam logic [1:0] CFG_MAXIT  = 2'd0;
	localparam logic [1:0] CFG_TOL    = 2'd1;
	localparam logic [1:0] CFG_START  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_USCL_GO,
		S_USCL_WAIT,
		S_MUL_GO,
		S_MUL_WAIT,
		S_DCHK,
		S_SAT,
		S_QDIV_WAIT,
		S_UPD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic            start;
		logic [DVW-1:0]  dividend;
		logic [AW-1:0]   divisor;
		logic [CNTW-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [QW-1:0] quotient;
	} div_rsp_t;

	// calibration coefficients, 28 fractional bits, u = I/300
	function automatic logic signed [AW-1:0] coef_f(input logic [2:0] m, input logic [2:0] k);
		logic signed [AW-1:0] c;
		c = '0;
		case (m)
			3'd0: begin
				case (k)
					3'd0: c = 40'sd412406;
					3'd1: c = 40'sd198825275;
					3'd2: c = -40'sd532428;
					3'd3: c = 40'sd9668867;
					3'd4: c = 40'sd216910;
					3'd5: c = -40'sd31018133;
					default: c = '0;
				endcase
			end
			3'd1: begin
				case (k)
					3'd0: c = 40'sd5984653;
					3'd1: c = 40'sd1631273413;
					3'd2: c = 40'sd9056678;
					3'd3: c = 40'sd31533692;
					3'd4: c = -40'sd13687550;
					3'd5: c = -40'sd64547418;
					default: c = '0;
				endcase
			end
			3'd2: begin
				case (k)
					3'd0: c = 40'sd234739;
					3'd1: c = 40'sd1912149074;
					3'd2: c = -40'sd975333;
					3'd3: c = -40'sd39950107;
					3'd4: c = 40'sd779077;
					3'd5: c = -40'sd237779878;
					default: c = '0;
				endcase
			end
			3'd3: begin
				case (k)
					3'd0: c = 40'sd64708;
					3'd1: c = 40'sd1947183141;
					3'd2: c = -40'sd273670;
					3'd3: c = -40'sd49847274;
					3'd4: c = 40'sd231037;
					3'd5: c = -40'sd241751982;
					default: c = '0;
				endcase
			end
			3'd4: begin
				case (k)
					3'd0: c = -40'sd10475;
					3'd1: c = 40'sd2178434256;
					3'd2: c = -40'sd43000;
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	// derivative coefficients: k * c_k
	function automatic logic signed [AW-1:0] dcoef_f(input logic [2:0] m, input logic [2:0] k);
		logic signed [AW-1:0] c;
		logic signed [AW-1:0] r;
		c = coef_f(m, k);
		case (k)
			3'd1: r = c;
			3'd2: r = c <<< 1;
			3'd3: r = c + (c <<< 1);
			3'd4: r = c <<< 2;
			3'd5: r = c + (c <<< 2);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[sv/mcc_mul.sv]
// Signed-by-unsigned fixed point multiplier, product truncated toward zero.
module mcc_mul import mcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic        [UW-1:0] b,
	output logic                 done,
	output logic signed [AW-1:0] res
);

	logic [AW-1:0]    mag_in;
	logic [AW+HW-1:0] pp_lo;
	logic [AW+HW-1:0] pp_hi;
	logic [AW-1:0]    mag_q;
	logic [HW-1:0]    bhi_q;
	logic             neg_q;
	logic [AW+UW:0]   p_q;
	logic             ph_q;
	logic             done_q;
	logic [AW-1:0]    shr;

	// magnitude of the signed operand and the two partial products
	assign mag_in = a[AW-1] ? AW'(-a) : AW'(a);
	assign pp_lo  = mag_in * b[HW-1:0];
	assign pp_hi  = mag_q * bhi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ph_q   <= start;
			done_q <= ph_q;
		end
	end

	// low half first, high half accumulated next cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			bhi_q <= b[UW-1:HW];
			neg_q <= a[AW-1];
			p_q   <= (AW+UW+1)'(pp_lo);
		end else if (ph_q) begin
			p_q <= p_q + ((AW+UW+1)'(pp_hi) << HW);
		end
	end

	// drop the fraction, restore the sign
	assign shr  = AW'(p_q >> IQ);
	assign res  = neg_q ? -$signed(shr) : $signed(shr);
	assign done = done_q;

endmodule

[sv/mcc_div.sv]
// Restoring divider, one quotient bit per cycle, used for the Newton step.
module mcc_div import mcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  dsh_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DVW-1:0]  dsh_init;
	logic            ge;

	assign dsh_init = DVW'(req.divisor) << (req.nbits - 1'b1);
	assign ge       = rem_q >= dsh_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder, shifted divisor and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= dsh_init;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[sv/magnet_field_current_convert.sv]
// Top level: request sequencer and datapath for field/current conversion of five magnets.
// One request at a time. A current-to-field request is the scaling of current to u by a
// reciprocal product, then five Horner steps, each one pass of the shared multiplier. A
// field-to-current request runs Newton iterations: each iteration uses the shared
// multiplier ten times (scaling, polynomial and derivative) and, unless its step
// saturates, the restoring divider once for 26 quotient bits. A bad magnet, or a zero
// iteration cap on a field-to-current request, goes straight to the output state. A
// finished result sits in the output register while the next request is accepted.
// Configuration writes take effect at once and are meant for an idle block.
module magnet_field_current_convert import mcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [XW-1:0]      cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [2:0]         magnet_select,
	input  logic signed [31:0] operand_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	output logic [ITW-1:0]     iterations_used
);

	state_t state_q, state_d;

	// configuration
	logic [ITW-1:0] max_iter_q;
	logic [15:0]    tol_q;
	logic [XW-1:0]  start_q;

	// request and iteration registers
	logic                  op_q;
	logic [2:0]            msel_q;
	logic signed [31:0]    v_q;
	logic [XW-1:0]         x_q;
	logic signed [FQW-1:0] fq_q;
	logic [UW-1:0]         u_q;
	logic signed [AW-1:0]  acc_q;
	logic [2:0]            k_q;
	logic                  deriv_q;
	logic signed [AW-1:0]  poly_q;
	logic signed [AW-1:0]  d_q;
	logic [DVW-1:0]        nmag_q;
	logic [AW-1:0]         dmag_q;
	logic                  sneg_q;
	logic [SW-1:0]         step_q;
	logic [ITW-1:0]        it_q;
	logic signed [31:0]    res_q;
	logic [1:0]            stat_q;
	logic [ITW-1:0]        iter_q;
	logic                  out_valid_q;
	logic signed [31:0]    result_value_q;
	logic [1:0]            status_q;
	logic [ITW-1:0]        iterations_used_q;

	// shared units
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic                 mul_start;
	logic                 mul_done;
	logic signed [AW-1:0] mul_res;

	// combinational helpers
	logic [2:0]            midx;
	logic                  bad_mag;
	logic [XW-1:0]         x_in;
	logic signed [31:0]    f_clamped;
	logic [XW-1:0]         x_start;
	logic [XW-1:0]         x_first;
	logic signed [AW-1:0]  nacc;
	logic                  last_k;
	logic [AW-1:0]         nacc_mag;
	logic [31:0]           f_mag;
	logic signed [31:0]    f_out;
	logic signed [AW:0]    rdiff;
	logic signed [AW+9:0]  rx;
	logic signed [AW+9:0]  num;
	logic [AW+9:0]         num_mag;
	logic [AW-1:0]         d_mag;
	logic                  sat;
	logic signed [SW:0]    step_s;
	logic signed [XW+2:0]  xsum;
	logic [XW-1:0]         xn;
	logic                  conv;
	logic                  last_it;
	logic [ITW-1:0]        it_inc;
	logic                  out_free;

	mcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mcc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (acc_q),
		.b      (u_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	// operand conditioning
	assign midx    = msel_q - 3'd1;
	assign bad_mag = (msel_q == 3'd0) || (msel_q > 3'd5);
	assign x_in    = (v_q < 0) ? '0 :
			(v_q > $signed({7'b0, CUR_MAX})) ? CUR_MAX : v_q[XW-1:0];
	assign f_clamped = (v_q < -FIELD_LIM) ? -FIELD_LIM :
			(v_q > FIELD_LIM) ? FIELD_LIM : v_q;
	assign x_start = (start_q > CUR_MAX) ? CUR_MAX : start_q;
	assign x_first = (op_q == OP_C2F) ? x_in : x_start;

	// Horner step result
	assign nacc   = mul_res + (deriv_q ? dcoef_f(midx, k_q) : coef_f(midx, k_q));
	assign last_k = deriv_q ? (k_q == 3'd1) : (k_q == 3'd0);

	// field in output LSBs, truncated toward zero
	assign nacc_mag = nacc[AW-1] ? AW'(-nacc) : AW'(nacc);
	assign f_mag    = 32'(nacc_mag >> CUR_TO_Q_SH);
	assign f_out    = nacc[AW-1] ? -$signed(f_mag) : $signed(f_mag);

	// Newton numerator (B - F) * 300 and divisor magnitude
	assign rdiff   = (AW+1)'(fq_q) - (AW+1)'(poly_q);
	assign rx      = (AW+10)'(rdiff);
	assign num     = (rx <<< 8) + (rx <<< 5) + (rx <<< 3) + (rx <<< 2);
	assign num_mag = num[AW+9] ? (AW+10)'(-num) : (AW+10)'(num);
	assign d_mag   = d_q[AW-1] ? AW'(-d_q) : AW'(d_q);
	assign sat     = nmag_q >= (DVW'(dmag_q) << STEP_SH);

	// iterate update with saturation to 0..500 A
	assign step_s  = sneg_q ? -$signed({1'b0, step_q}) : $signed({1'b0, step_q});
	assign xsum    = $signed({3'b0, x_q}) + (XW+3)'(step_s);
	assign xn      = (xsum < 0) ? '0 :
			(xsum > $signed({3'b0, CUR_MAX})) ? CUR_MAX : xsum[XW-1:0];
	assign conv    = step_q <= SW'(tol_q);
	assign it_inc  = it_q + 1'b1;
	assign last_it = it_inc == max_iter_q;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (bad_mag) state_d = S_OUT;
				else if (op_q == OP_F2C && max_iter_q == '0) state_d = S_OUT;
				else state_d = S_USCL_GO;
			end
			S_USCL_GO: state_d = S_USCL_WAIT;
			S_USCL_WAIT: if (mul_done) state_d = S_MUL_GO;
			S_MUL_GO: state_d = S_MUL_WAIT;
			S_MUL_WAIT: begin
				if (mul_done) begin
					if (!last_k) state_d = S_MUL_GO;
					else if (deriv_q) state_d = S_DCHK;
					else if (op_q == OP_C2F) state_d = S_OUT;
					else state_d = S_MUL_GO;
				end
			end
			S_DCHK: state_d = (d_q == '0) ? S_OUT : S_SAT;
			S_SAT: state_d = sat ? S_UPD : S_QDIV_WAIT;
			S_QDIV_WAIT: if (div_rsp.done) state_d = S_UPD;
			S_UPD: state_d = (conv || last_it) ? S_OUT : S_USCL_GO;
			S_OUT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// unit control and handshake
	always_comb begin
		in_ready         = state_q == S_IDLE;
		mul_start        = (state_q == S_MUL_GO) || (state_q == S_USCL_GO);
		div_req.start    = 1'b0;
		div_req.dividend = nmag_q;
		div_req.divisor  = dmag_q;
		div_req.nbits    = CNTW'(STEP_SH);
		case (state_q)
			S_SAT: div_req.start = !sat;
			default: div_req.start = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			max_iter_q  <= MAX_ITER_RST;
			tol_q       <= TOL_RST;
			start_q     <= START_RST;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					CFG_MAXIT: max_iter_q <= cfg_data[ITW-1:0];
					CFG_TOL:   tol_q <= cfg_data[15:0];
					CFG_START: start_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= operation;
				msel_q <= magnet_select;
				v_q    <= operand_value;
			end
			S_CHECK: begin
				res_q  <= '0;
				iter_q <= '0;
				it_q   <= '0;
				stat_q <= bad_mag ? ST_BADMAG : ST_NOCONV;
				fq_q   <= FQW'(f_clamped) <<< CUR_TO_Q_SH;
				x_q    <= x_first;
				// scaling operands for the reciprocal product
				u_q    <= UW'(x_first);
				acc_q  <= U_RECIP;
			end
			S_USCL_WAIT: begin
				if (mul_done) begin
					u_q     <= mul_res[UW+U_RECIP_SH-1:U_RECIP_SH];
					acc_q   <= coef_f(midx, 3'd5);
					k_q     <= 3'd4;
					deriv_q <= 1'b0;
				end
			end
			S_MUL_WAIT: begin
				if (mul_done) begin
					if (!last_k) begin
						acc_q <= nacc;
						k_q   <= k_q - 3'd1;
					end else if (!deriv_q) begin
						poly_q  <= nacc;
						acc_q   <= dcoef_f(midx, 3'd5);
						k_q     <= 3'd4;
						deriv_q <= 1'b1;
						res_q   <= f_out;
						stat_q  <= ST_OK;
						iter_q  <= '0;
					end else begin
						d_q <= nacc;
					end
				end
			end
			S_DCHK: begin
				nmag_q <= DVW'(num_mag) << FRAC_BITS;
				dmag_q <= d_mag;
				sneg_q <= num[AW+9] ^ d_q[AW-1];
				res_q  <= '0;
				stat_q <= ST_NOCONV;
				iter_q <= it_inc;
			end
			S_SAT: if (sat) step_q <= SW'(1) << STEP_SH;
			S_QDIV_WAIT: if (div_rsp.done) step_q <= SW'(div_rsp.quotient);
			S_UPD: begin
				x_q   <= xn;
				it_q  <= it_inc;
				u_q   <= UW'(xn);
				acc_q <= U_RECIP;
				if (conv) begin
					res_q  <= $signed(32'(xn));
					stat_q <= ST_OK;
					iter_q <= it_inc;
				end else begin
					res_q  <= '0;
					stat_q <= ST_NOCONV;
					iter_q <= max_iter_q;
				end
			end
			S_OUT: begin
				if (out_free) begin
					result_value_q    <= res_q;
					status_q          <= stat_q;
					iterations_used_q <= iter_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign result_value    = result_value_q;
	assign status          = status_q;
	assign iterations_used = iterations_used_q;

endmodule

[sv/mcc_checker.sv]
// Port-level checks for the converter, bound to the top level.
module mcc_checker import mcc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_write,
	input logic [1:0]         cfg_index,
	input logic [XW-1:0]      cfg_data,
	input logic               in_valid,
	input logic               in_ready,
	input logic               operation,
	input logic [2:0]         magnet_select,
	input logic signed [31:0] operand_value,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] result_value,
	input logic [1:0]         status,
	input logic [ITW-1:0]     iterations_used
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) &&
		$stable(status) && $stable(iterations_used))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// bad magnet gives zero result and no iterations
	a_badmag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BADMAG |-> result_value == 0 && iterations_used == '0)
		else $error("bad magnet result not cleared");

	// non-convergence reports zero
	a_noconv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOCONV |-> result_value == 0)
		else $error("non-converged result not zero");

endmodule

bind magnet_field_current_convert mcc_checker u_mcc_checker (.*);

[tb/sv/testbench.sv]
// Testbench for the magnet field/current converter: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module testbench;
	import mcc_pkg::*;

	localparam longint CUR_ONE   = 64'sd65536;
	localparam longint Q_ONE     = 64'sd1 << 28;
	localparam longint CUR_TO_Q  = Q_ONE / CUR_ONE;
	localparam longint AMP_LIMIT = 500 * CUR_ONE;
	localparam longint KG_LIMIT  = 64 * CUR_ONE;
	localparam longint STEP_CAP  = 1024 * CUR_ONE;
	localparam longint OUT_CAP   = 64'sd2147483647;
	localparam int     CYCLE_CAP = 40_000_000;
	localparam int     SETTLE    = 200;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic [ITW-1:0]     iters;
	} conversion_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = CFG_MAXIT;
	logic [XW-1:0]      cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = OP_C2F;
	logic [2:0]         magnet_select = 3'd1;
	logic signed [31:0] operand_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;
	logic [ITW-1:0]     iterations_used;

	// model copy of the registers
	int unsigned iter_cap = 1000;
	int unsigned step_tol = 1;
	int unsigned first_guess = 65536;

	conversion_t expected_conversions[$];
	int          errors = 0;
	int          cycles = 0;
	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;

	magnet_field_current_convert DUT (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// calibration table on the 28-bit grid
	function automatic longint scaled(longint n, longint d, longint sn, longint sd);
		return ((n * Q_ONE) / d * sn) / sd;
	endfunction

	function automatic longint calib(int m, int k);
		case (m)
			0: case (k)
				0: return scaled(110605, 10000000, 50800, 365723);
				1: return scaled(533237, 100000, 50800, 365723);
				2: return scaled(-142794, 10000000, 50800, 365723);
				3: return scaled(259313, 1000000, 50800, 365723);
				4: return scaled(58174, 10000000, 50800, 365723);
				default: return scaled(-831887, 1000000, 50800, 365723);
			endcase
			1: case (k)
				0: return scaled(196438, 10000000, 5080, 4476);
				1: return scaled(535443, 100000, 5080, 4476);
				2: return scaled(297273, 10000000, 5080, 4476);
				3: return scaled(103505, 1000000, 5080, 4476);
				4: return scaled(-449275, 10000000, 5080, 4476);
				default: return scaled(-211868, 1000000, 5080, 4476);
			endcase
			2: case (k)
				0: return scaled(632446, 1000000000, 5080, 3674);
				1: return scaled(515178, 100000, 5080, 3674);
				2: return scaled(-262778, 100000000, 5080, 3674);
				3: return scaled(-107635, 1000000, 5080, 3674);
				4: return scaled(209902, 100000000, 5080, 3674);
				default: return scaled(-640635, 1000000, 5080, 3674);
			endcase
			3: case (k)
				0: return scaled(1732, 10000000, 5080, 3650);
				1: return scaled(52119, 10000, 5080, 3650);
				2: return scaled(-732518, 1000000000, 5080, 3650);
				3: return scaled(-133423, 1000000, 5080, 3650);
				4: return scaled(618402, 1000000000, 5080, 3650);
				default: return scaled(-647082, 1000000, 5080, 3650);
			endcase
			default: case (k)
				0: return (-64'sd39026 * Q_ONE) / 1000000000;
				1: return (64'sd81153 * Q_ONE) / 10000;
				2: return (-64'sd160191 * Q_ONE) / 1000000000;
				default: return 0;
			endcase
		endcase
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint amps_to_u(longint amps);
		return (amps * CUR_TO_Q) / 300;
	endfunction

	// Horner evaluation of the field and its slope
	function automatic longint field_of(int m, longint u);
		longint acc;
		acc = calib(m, 5);
		for (int k = 4; k >= 0; k--)
			acc = (acc * u) / Q_ONE + calib(m, k);
		return acc;
	endfunction

	function automatic longint slope_of(int m, longint u);
		longint acc;
		acc = 5 * calib(m, 5);
		for (int k = 4; k >= 1; k--)
			acc = (acc * u) / Q_ONE + k * calib(m, k);
		return acc;
	endfunction

	function automatic conversion_t predict_conversion(logic op, logic [2:0] mag,
			logic signed [31:0] val);
		conversion_t res;
		longint x, fq, u, r, d, num, q, rem, step, mag_step;
		int m;
		res.value = '0;
		res.status = ST_OK;
		res.iters = '0;
		if (mag < 1 || mag > 5) begin
			res.status = ST_BADMAG;
			return res;
		end
		m = mag - 1;
		if (op == OP_C2F) begin
			x = clip(longint'(val), 0, AMP_LIMIT);
			res.value = 32'(field_of(m, amps_to_u(x)) / CUR_TO_Q);
			return res;
		end
		// Newton inverse
		fq = clip(longint'(val), -KG_LIMIT, KG_LIMIT) * CUR_TO_Q;
		x = clip(longint'(first_guess), 0, AMP_LIMIT);
		for (int unsigned it = 0; it < iter_cap; it++) begin
			u = amps_to_u(x);
			r = fq - field_of(m, u);
			d = slope_of(m, u);
			if (d == 0) begin
				res.status = ST_NOCONV;
				res.iters = ITW'(it + 1);
				return res;
			end
			num = r * 300;
			q = num / d;
			rem = num % d;
			if (q >= 1024)
				step = STEP_CAP;
			else if (q <= -1024)
				step = -STEP_CAP;
			else
				step = q * CUR_ONE + (rem * CUR_ONE) / d;
			x = clip(x + step, 0, AMP_LIMIT);
			mag_step = step < 0 ? -step : step;
			if (mag_step <= longint'(step_tol)) begin
				res.value = 32'(x > OUT_CAP ? OUT_CAP : x);
				res.iters = ITW'(it + 1);
				return res;
			end
		end
		res.status = ST_NOCONV;
		res.iters = ITW'(iter_cap);
		return res;
	endfunction

	// run-length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		conversion_t exp_res;
		if (out_valid && out_ready) begin
			if (expected_conversions.size() == 0) begin
				$error("unexpected result: value %0d status %0d iterations %0d",
					result_value, status, iterations_used);
				errors++;
			end else begin
				exp_res = expected_conversions.pop_front();
				if (result_value !== exp_res.value) begin
					$error("result_value: expected %0d, actual %0d", exp_res.value, result_value);
					errors++;
				end
				if (status !== exp_res.status) begin
					$error("status: expected %0d, actual %0d", exp_res.status, status);
					errors++;
				end
				if (iterations_used !== exp_res.iters) begin
					$error("iterations_used: expected %0d, actual %0d",
						exp_res.iters, iterations_used);
					errors++;
				end
			end
		end
	end

	// one request; returns after the acceptance edge and any sender gap
	task automatic send_request(logic op, logic [2:0] mag, logic signed [31:0] val);
		operation <= op;
		magnet_select <= mag;
		operand_value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_conversions.push_back(predict_conversion(op, mag, val));
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_conversions.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [XW-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_MAXIT: iter_cap = data[9:0];
			CFG_TOL:   step_tol = data[15:0];
			CFG_START: first_guess = data;
			default: ;
		endcase
	endtask

	task automatic set_regs(int unsigned cap, int unsigned tol, int unsigned guess);
		write_reg(CFG_MAXIT, XW'(cap));
		write_reg(CFG_TOL, XW'(tol));
		write_reg(CFG_START, XW'(guess));
	endtask

	// reset defaults: bad magnets, current extremes, reachable fields
	task automatic test_directed_defaults;
		send_request(OP_C2F, 3'd0, 32'sd1000);
		send_request(OP_F2C, 3'd6, 32'sd1000);
		send_request(OP_C2F, 3'd7, -32'sd1);
		send_request(OP_F2C, 3'd0, 32'sh7fffffff);
		for (int m = 1; m <= 5; m++) begin
			send_request(OP_C2F, 3'(m), 32'sh80000000);
			send_request(OP_C2F, 3'(m), 32'sh7fffffff);
			send_request(OP_C2F, 3'(m), 32'(AMP_LIMIT));
			send_request(OP_F2C, 3'(m),
				32'(field_of(m - 1, amps_to_u(150 * CUR_ONE)) / CUR_TO_Q));
		end
		send_request(OP_F2C, 3'd2, 32'sd0);
		drain();
	endtask

	// register extremes: single step, zero cap, zero tolerance, clipped start guess
	task automatic test_register_extremes;
		set_regs(1, 65535, 0);
		send_request(OP_F2C, 3'd1, 32'sh7fffffff);
		send_request(OP_F2C, 3'd5, 32'sh80000000);
		drain();
		set_regs(0, 1, 65536);
		send_request(OP_F2C, 3'd3, 32'sd100000);
		drain();
		set_regs(30, 0, 32768000);
		send_request(OP_F2C, 3'd4, 32'sd4194304);
		send_request(OP_F2C, 3'd2, -32'sd4194304);
		drain();
		set_regs(12, 4, 33554431);
		send_request(OP_F2C, 3'd5, 32'sd2000000);
		drain();
	endtask

	function automatic logic [2:0] pick_magnet;
		return ($urandom_range(9) == 0) ? 3'($urandom_range(1) ? 0 : $urandom_range(7, 6))
			: 3'($urandom_range(5, 1));
	endfunction

	// random requests under one idling pattern and one register setting
	task automatic test_random_phase(int idle_pct, int stall_pct, int count);
		logic [2:0] mag;
		int unsigned sel;
		logic signed [31:0] val;
		logic op;
		sel = $urandom_range(3);
		set_regs($urandom_range(40, 4),
			sel == 0 ? 0 : sel == 1 ? 1 : sel == 2 ? $urandom_range(64) : $urandom_range(65535),
			$urandom_range(1) ? $urandom_range(32768000) : $urandom_range(33554431));
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			// occasional hold-off until the block has emptied
			if ($urandom_range(49) == 0) begin
				in_valid <= 1'b0;
				while (expected_conversions.size() != 0) @(posedge clk);
			end
			op = $urandom_range(1);
			mag = pick_magnet();
			sel = $urandom_range(9);
			if (sel == 0)
				val = $urandom;
			else if (op == OP_C2F)
				val = $urandom_range(32'(AMP_LIMIT));
			else if (sel < 7 && mag >= 1 && mag <= 5)
				val = 32'(field_of(mag - 1, amps_to_u($urandom_range(32'(AMP_LIMIT))))
					/ CUR_TO_Q);
			else
				val = $signed($urandom_range(2 * 32'(KG_LIMIT))) - 32'(KG_LIMIT);
			send_request(op, mag, val);
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_register_extremes();
		test_random_phase(0, 0, 375);
		test_random_phase(63, 0, 375);
		test_random_phase(0, 63, 375);
		test_random_phase(10, 10, 375);
		receiver_stall_pct = 0;
		drain();
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
